[hw/rtl/quad_pointer_hit_test_unit_defines.svh]
// Assertion macros used by the quad pointer hit test top level.
`ifndef QUAD_POINTER_HIT_TEST_UNIT_DEFINES_SVH
`define QUAD_POINTER_HIT_TEST_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define QPHTU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("qphtu assertion failed");

// Implication checked in the same cycle.
`define QPHTU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qphtu implication failed");

// Implication checked in the next cycle.
`define QPHTU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qphtu next-cycle implication failed");

`endif

[hw/rtl/qphtu_pkg.sv]
// Types, constants and register codes for the quad pointer hit test unit.
`timescale 1ns / 1ps

package qphtu_pkg;

   localparam int CoordWidth = 12;
   localparam int NumCorners = 4;
   localparam int NumEdges   = 4;
   localparam int IndexWidth = 2;
   localparam int CountWidth = 3;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int ProdWidth  = 2 * DiffWidth;
   localparam int CrossWidth = ProdWidth + 1;
   localparam int BoxWidth   = CoordWidth + 2;

   localparam int HANDLE_HALF = 20;
   localparam int RAY_BOTTOM  = 600;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
   } point_type;

   // Crossing flags of one edge against the upward and the downward ray.
   typedef struct packed {
      logic up;
      logic down;
   } edge_res_type;

   typedef struct packed {
      logic                  hit;
      logic [IndexWidth-1:0] index;
   } handle_res_type;

   typedef enum logic [2:0] {
      REG_CORNER0_X = 3'd0,
      REG_CORNER0_Y = 3'd1,
      REG_CORNER1_X = 3'd2,
      REG_CORNER1_Y = 3'd3,
      REG_CORNER2_X = 3'd4,
      REG_CORNER2_Y = 3'd5,
      REG_CORNER3_X = 3'd6,
      REG_CORNER3_Y = 3'd7
   } csr_reg_type;

   localparam point_type CornerReset [NumCorners] = '{
      '{x: 12'sd200, y: 12'sd150},
      '{x: 12'sd200, y: 12'sd450},
      '{x: 12'sd600, y: 12'sd450},
      '{x: 12'sd600, y: 12'sd150}
   };

   // Edge list: 0-3, 1-2, 0-1, 3-2.
   localparam int EdgeFirst  [NumEdges] = '{0, 1, 0, 3};
   localparam int EdgeSecond [NumEdges] = '{3, 2, 1, 2};

endpackage

[hw/rtl/qphtu_edge_test.sv]
// Segment crossing test of one quad edge against the upward and downward rays.
`timescale 1ns / 1ps

module qphtu_edge_test (
   input  qphtu_pkg::point_type    corner_a,
   input  qphtu_pkg::point_type    corner_b,
   input  qphtu_pkg::point_type    point_i,
   output qphtu_pkg::edge_res_type result_o
);
   import qphtu_pkg::*;

   localparam int NumEnds = 2;

   // Orientation cross product of (a, b) seen from c.
   function automatic logic signed [CrossWidth-1:0] cross_prod(
      point_type a, point_type b, point_type c);
      logic signed [DiffWidth-1:0] ax, ay, bx, by;
      logic signed [ProdWidth-1:0] m0, m1;
      ax = $signed({a.x[CoordWidth-1], a.x}) - $signed({c.x[CoordWidth-1], c.x});
      ay = $signed({a.y[CoordWidth-1], a.y}) - $signed({c.y[CoordWidth-1], c.y});
      bx = $signed({b.x[CoordWidth-1], b.x}) - $signed({c.x[CoordWidth-1], c.x});
      by = $signed({b.y[CoordWidth-1], b.y}) - $signed({c.y[CoordWidth-1], c.y});
      m0 = ax * by;
      m1 = ay * bx;
      return $signed({m0[ProdWidth-1], m0}) - $signed({m1[ProdWidth-1], m1});
   endfunction

   // c within the bounding box of a and b, borders included.
   function automatic logic in_box(point_type a, point_type b, point_type c);
      logic x_ok, y_ok;
      x_ok = (a.x < b.x) ? (c.x >= a.x && c.x <= b.x) : (c.x >= b.x && c.x <= a.x);
      y_ok = (a.y < b.y) ? (c.y >= a.y && c.y <= b.y) : (c.y >= b.y && c.y <= a.y);
      return x_ok && y_ok;
   endfunction

   point_type                   ray_end [NumEnds];
   logic signed [CrossWidth-1:0] cross_pt;
   logic                        pt_pos, pt_neg;
   logic                        straddle;
   logic [NumEnds-1:0]          hit_end;

   assign ray_end[0] = '{x: point_i.x, y: '0};
   assign ray_end[1] = '{x: point_i.x, y: CoordWidth'(RAY_BOTTOM)};

   assign cross_pt = cross_prod(corner_a, corner_b, point_i);
   assign pt_neg   = cross_pt[CrossWidth-1];
   assign pt_pos   = !pt_neg && (cross_pt != '0);

   // Edge ends on strictly opposite sides of the vertical line x = point x.
   assign straddle = (point_i.x > corner_a.x && point_i.x < corner_b.x) ||
                     (point_i.x < corner_a.x && point_i.x > corner_b.x);

   for (genvar e = 0; e < NumEnds; e++) begin : g_ray
      logic signed [CrossWidth-1:0] cross_end;
      logic                        end_pos, end_neg, proper;

      assign cross_end = cross_prod(corner_a, corner_b, ray_end[e]);
      assign end_neg   = cross_end[CrossWidth-1];
      assign end_pos   = !end_neg && (cross_end != '0);
      assign proper    = straddle && (ray_end[e].y != point_i.y) &&
                         ((pt_pos && end_neg) || (pt_neg && end_pos));

      // Touching cases: an edge end on the ray, or a ray end on the edge.
      assign hit_end[e] = proper ||
                          in_box(point_i, ray_end[e], corner_a) ||
                          in_box(point_i, ray_end[e], corner_b) ||
                          (cross_pt == '0 && in_box(corner_a, corner_b, point_i)) ||
                          (cross_end == '0 && in_box(corner_a, corner_b, ray_end[e]));
   end

   assign result_o = '{up: hit_end[0], down: hit_end[1]};

endmodule

[hw/rtl/qphtu_handle_check.sv]
// Corner handle box test with lowest-index priority.
`timescale 1ns / 1ps

module qphtu_handle_check (
   input  qphtu_pkg::point_type      corner_i [qphtu_pkg::NumCorners],
   input  qphtu_pkg::point_type      point_i,
   output qphtu_pkg::handle_res_type result_o
);
   import qphtu_pkg::*;

   logic [NumCorners-1:0] in_handle;

   for (genvar c = 0; c < NumCorners; c++) begin : g_corner
      logic signed [BoxWidth-1:0] cx, cy, px, py;

      assign cx = $signed({{2{corner_i[c].x[CoordWidth-1]}}, corner_i[c].x});
      assign cy = $signed({{2{corner_i[c].y[CoordWidth-1]}}, corner_i[c].y});
      assign px = $signed({{2{point_i.x[CoordWidth-1]}}, point_i.x});
      assign py = $signed({{2{point_i.y[CoordWidth-1]}}, point_i.y});

      assign in_handle[c] = (px >= cx - BoxWidth'(HANDLE_HALF)) &&
                            (px <= cx + BoxWidth'(HANDLE_HALF)) &&
                            (py >= cy - BoxWidth'(HANDLE_HALF)) &&
                            (py <= cy + BoxWidth'(HANDLE_HALF));
   end

   always_comb begin
      result_o = '{hit: 1'b0, index: '0};
      for (int i = NumCorners - 1; i >= 0; i--) begin
         if (in_handle[i]) begin
            result_o = '{hit: 1'b1, index: IndexWidth'(i)};
         end
      end
   end

endmodule

[hw/rtl/quad_pointer_hit_test_unit.sv]
// Top level of the quad pointer hit test unit: config registers and item pipeline.
`timescale 1ns / 1ps
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  req     | in        | req_tvalid/req_tready  | tdata: point_x, point_y
//  rsp     | out       | rsp_tvalid/rsp_tready  | tuser: handle_hit; tdata: result
//  csr     | in        | csr_valid/csr_ready    | csr_index, csr_wdata (corner coords)
//
//  One item per cycle sustained while rsp is not stalled; an item taken on req passes
//  the input register, then the result register (all geometry sits between the two).
//  The path is set by the edge cross products: 24 parallel 13x13 multipliers,
//  one subtract and a sign compare, then the crossing count.
//  Reset (synchronous) empties both stages and loads the default quad corners.
//  A stall on rsp holds the result register; req_tready then drops only once
//  the input register also holds an item. csr_ready is always high.

module quad_pointer_hit_test_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [11:0] point_x, [23:12] point_y

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] handle_index, [2] inside_res,
                                    // [5:3] crossing_count, [6] used_down_ray, [7] zero
   output logic [0:0]  rsp_tuser,   // [0] handle_hit

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import qphtu_pkg::*;

   `include "quad_pointer_hit_test_unit_defines.svh"

   // Corner configuration.
   point_type corner_ff [NumCorners];
   point_type corner_in [NumCorners];

   // Input stage.
   logic      pt_valid_ff, pt_valid_in;
   point_type pt_ff, pt_in;

   // Result stage.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [IndexWidth-1:0] rsp_index_ff, rsp_index_in;
   logic                  rsp_inside_ff, rsp_inside_in;
   logic [CountWidth-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_down_ff, rsp_down_in;

   logic rsp_advance;

   handle_res_type        handle_res;
   edge_res_type          edge_res [NumEdges];
   logic [CountWidth-1:0] up_count, down_count;

   assign csr_ready = 1'b1;

   always_comb begin
      corner_in = corner_ff;
      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_CORNER0_X: corner_in[0].x = csr_wdata;
            REG_CORNER0_Y: corner_in[0].y = csr_wdata;
            REG_CORNER1_X: corner_in[1].x = csr_wdata;
            REG_CORNER1_Y: corner_in[1].y = csr_wdata;
            REG_CORNER2_X: corner_in[2].x = csr_wdata;
            REG_CORNER2_Y: corner_in[2].y = csr_wdata;
            REG_CORNER3_X: corner_in[3].x = csr_wdata;
            REG_CORNER3_Y: corner_in[3].y = csr_wdata;
            default:       corner_in = corner_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= CornerReset;
      end else begin
         corner_ff <= corner_in;
      end
   end

   // Handshake: the result register frees up when empty or taken this cycle.
   assign rsp_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !pt_valid_ff || rsp_advance;

   assign pt_valid_in = req_tready ? req_tvalid : pt_valid_ff;
   assign pt_in       = req_tready ? point_type'({req_tdata[11:0], req_tdata[23:12]}) : pt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff <= 1'b0;
      end else begin
         pt_valid_ff <= pt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
   end

   // Geometry on the registered point.
   qphtu_handle_check u_handle (
      .corner_i (corner_ff),
      .point_i  (pt_ff),
      .result_o (handle_res)
   );

   for (genvar e = 0; e < NumEdges; e++) begin : g_edge
      qphtu_edge_test u_edge (
         .corner_a (corner_ff[EdgeFirst[e]]),
         .corner_b (corner_ff[EdgeSecond[e]]),
         .point_i  (pt_ff),
         .result_o (edge_res[e])
      );
   end

   always_comb begin
      up_count   = '0;
      down_count = '0;
      for (int i = 0; i < NumEdges; i++) begin
         up_count   = up_count + CountWidth'(edge_res[i].up);
         down_count = down_count + CountWidth'(edge_res[i].down);
      end
   end

   // A handle hit wins; otherwise fall back to the downward ray on a zero count.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_down_in   = rsp_down_ff;
      if (rsp_advance) begin
         rsp_valid_in = pt_valid_ff;
         rsp_hit_in   = handle_res.hit;
         rsp_index_in = handle_res.index;
         if (handle_res.hit) begin
            rsp_count_in = '0;
            rsp_down_in  = 1'b0;
         end else if (up_count == '0) begin
            rsp_count_in = down_count;
            rsp_down_in  = 1'b1;
         end else begin
            rsp_count_in = up_count;
            rsp_down_in  = 1'b0;
         end
         rsp_inside_in = rsp_count_in[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff    <= rsp_hit_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_down_ff   <= rsp_down_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {1'b0, rsp_down_ff, rsp_count_ff, rsp_inside_ff, rsp_index_ff};

   // Checks.
   `QPHTU_ASSERT_IMP(a_hit_clears_count, clock, reset, rsp_valid_ff && rsp_hit_ff,
      !rsp_inside_ff && rsp_count_ff == '0 && !rsp_down_ff)
   `QPHTU_ASSERT_IMP(a_inside_is_parity, clock, reset, rsp_valid_ff && !rsp_hit_ff,
      rsp_inside_ff == rsp_count_ff[0])
   `QPHTU_ASSERT_IMP(a_up_ray_nonzero, clock, reset,
      rsp_valid_ff && !rsp_hit_ff && !rsp_down_ff, rsp_count_ff != '0)
   `QPHTU_ASSERT(a_count_range, clock, reset, !rsp_valid_ff || rsp_count_ff <= 3'd4)
   `QPHTU_ASSERT_NEXT(a_input_holds, clock, reset, pt_valid_ff && !rsp_advance,
      pt_valid_ff && $stable(pt_ff))

endmodule
